// ----- design/adam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam update engine package
// Constants, pipeline stage types and per-stage step functions for the
// fixed-point Adam parameter update engine.
// ----------------------------------------------------------------------------
package adam_pkg;

  localparam int ENTRIES   = 65536;
  localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SQ_STAGES = 24;
  localparam int DV_STAGES = 33;

  localparam logic [31:0] M_KEEP     = 32'd3865470566;
  localparam logic [31:0] M_TAKE     = 32'd429496730;
  localparam logic [31:0] V_KEEP     = 32'd4290672329;
  localparam logic [22:0] V_TAKE     = 23'd4294967;
  localparam logic [31:0] STEP_RESET = 32'd16777;

  typedef struct packed {
    logic [15:0] idx;
    logic [31:0] p;
  } meta_t;

  typedef struct packed {
    logic [47:0] x;
    logic [23:0] root;
    logic [24:0] rem;
    logic [63:0] num;
    logic        neg;
    meta_t       meta;
  } sq_stage_t;

  typedef struct packed {
    logic [24:0] den;
    logic [24:0] rem;
    logic [32:0] lo;
    logic [32:0] quo;
    logic        ovf;
    logic        neg;
    meta_t       meta;
  } dv_stage_t;

  function automatic sq_stage_t sq_step(sq_stage_t s);
    logic [26:0] rem2;
    logic [26:0] trial;
    logic [26:0] diff;
    sq_stage_t   o;
    o     = s;
    rem2  = {s.rem, s.x[47:46]};
    trial = {1'b0, s.root, 2'b01};
    diff  = rem2 - trial;
    if (rem2 >= trial) begin
      o.rem  = diff[24:0];
      o.root = {s.root[22:0], 1'b1};
    end else begin
      o.rem  = rem2[24:0];
      o.root = {s.root[22:0], 1'b0};
    end
    o.x = {s.x[45:0], 2'b00};
    return o;
  endfunction

  function automatic dv_stage_t dv_step(dv_stage_t s);
    logic [25:0] rr;
    logic [25:0] diff;
    dv_stage_t   o;
    o    = s;
    rr   = {s.rem, s.lo[32]};
    diff = rr - {1'b0, s.den};
    if (rr >= {1'b0, s.den}) begin
      o.rem = diff[24:0];
      o.quo = {s.quo[31:0], 1'b1};
    end else begin
      o.rem = rr[24:0];
      o.quo = {s.quo[31:0], 1'b0};
    end
    o.lo = {s.lo[31:0], 1'b0};
    return o;
  endfunction

endpackage

// ----- design/adam_optimizer_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam parameter update engine
// Path: a request passes through stages 1 to 3, the square root stages, the divider
// stages and the output register. Throughput: one request per cycle while the output
// is not stalled; a request whose index matches one of the three requests in the
// moment read-modify-write stages waits until the moment memories are written back.
// Reset: step size returns to its reset value and a clearing pass zeroes both
// moment memories, one entry per cycle, before any request.
// ----------------------------------------------------------------------------
module adam_optimizer_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_step_size,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_entry_index,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_param_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_index,
  output logic signed [31:0] out_new_param
);
  import adam_pkg::*;

  logic [31:0]   step_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          adv;
  logic          hazard;
  logic          accept;

  logic [31:0]   m_mem [ENTRIES];
  logic [47:0]   v_mem [ENTRIES];
  logic [31:0]   rd_m_r;
  logic [47:0]   rd_v_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wm;
  logic [47:0]   mem_wv;

  logic          s1_vld_r;
  meta_t         s1_meta_r;
  logic [31:0]   s1_g_r;

  logic               s2_vld_r;
  meta_t              s2_meta_r;
  logic signed [63:0] s2_pm_r, s2_pm_nxt;
  logic signed [63:0] s2_pg_r, s2_pg_nxt;
  logic [63:0]        s2_sq_r, s2_sq_nxt;
  logic [63:0]        s2_pvl_r, s2_pvl_nxt;
  logic [47:0]        s2_pvh_r, s2_pvh_nxt;
  logic [31:0]        g_mag;

  logic               s3_vld_r;
  meta_t              s3_meta_r;
  logic [31:0]        s3_nm_r, s3_nm_nxt;
  logic [63:0]        s3_pvl_r;
  logic [47:0]        s3_pvh_r;
  logic [54:0]        s3_pbl_r, s3_pbl_nxt;
  logic [38:0]        s3_pbh_r, s3_pbh_nxt;
  logic signed [65:0] m_sum;
  logic [47:0]        g2;

  logic [49:0]   v_hi;
  logic [33:0]   v_fr;
  logic [49:0]   v_sum;
  logic [47:0]   v_new;
  logic [31:0]   m_mag;
  logic [63:0]   num;

  sq_stage_t          sq_r   [SQ_STAGES+1];
  sq_stage_t          sq_nxt [SQ_STAGES+1];
  logic [SQ_STAGES:0] sq_vld_r;
  dv_stage_t          dv_r   [DV_STAGES+1];
  dv_stage_t          dv_nxt [DV_STAGES+1];
  logic [DV_STAGES:0] dv_vld_r;

  logic [24:0]        den;
  logic [63:0]        n_full;
  logic [55:0]        n_shr;
  logic [33:0]        q_ext;
  logic signed [35:0] res_full;
  logic [31:0]        res_sat;

  logic               out_valid_r;
  logic [15:0]        out_index_r;
  logic [31:0]        out_param_r;

  // configuration and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_RESET;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_step_size;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(ENTRIES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // hold the whole pipeline only when its last stage cannot drain
  assign adv    = !dv_vld_r[DV_STAGES] || !out_valid_r || !out_stall;
  assign hazard = (s1_vld_r && (AW'(s1_meta_r.idx) == AW'(in_entry_index))) ||
                  (s2_vld_r && (AW'(s2_meta_r.idx) == AW'(in_entry_index))) ||
                  (s3_vld_r && (AW'(s3_meta_r.idx) == AW'(in_entry_index)));
  assign in_stall = clr_busy_r || !adv || hazard;
  assign accept   = in_valid && !in_stall;

  // moment memories
  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wm = '0;
      mem_wv = '0;
    end else begin
      mem_we = adv && s3_vld_r;
      mem_wa = AW'(s3_meta_r.idx);
      mem_wm = s3_nm_r;
      mem_wv = v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_mem[mem_wa] <= mem_wm;
      v_mem[mem_wa] <= mem_wv;
    end
    if (adv) begin
      rd_m_r <= m_mem[AW'(in_entry_index)];
      rd_v_r <= v_mem[AW'(in_entry_index)];
    end
  end

  // stage 1: products of the stored moments and the gradient
  always_comb begin
    g_mag      = s1_g_r[31] ? (~s1_g_r + 32'd1) : s1_g_r;
    s2_pm_nxt  = 64'($signed({1'b0, M_KEEP})) * 64'($signed(rd_m_r));
    s2_pg_nxt  = 64'($signed({1'b0, M_TAKE})) * 64'($signed(s1_g_r));
    s2_sq_nxt  = {32'd0, g_mag} * {32'd0, g_mag};
    s2_pvl_nxt = {32'd0, rd_v_r[31:0]} * {32'd0, V_KEEP};
    s2_pvh_nxt = {32'd0, rd_v_r[47:32]} * {16'd0, V_KEEP};
  end

  // stage 2: new first moment, weighted squared gradient
  always_comb begin
    m_sum      = 66'(s2_pm_r) + 66'(s2_pg_r) + $signed(66'sh80000000);
    s3_nm_nxt  = m_sum[63:32];
    g2         = s2_sq_r[63:16];
    s3_pbl_nxt = {23'd0, g2[31:0]} * {32'd0, V_TAKE};
    s3_pbh_nxt = {23'd0, g2[47:32]} * {16'd0, V_TAKE};
  end

  // stage 3: new second moment and update numerator
  always_comb begin
    v_hi  = 50'(s3_pvh_r) + 50'(s3_pbh_r) + 50'(s3_pvl_r[63:32]) + 50'(s3_pbl_r[54:32]);
    v_fr  = 34'(s3_pvl_r[31:0]) + 34'(s3_pbl_r[31:0]) + 34'h080000000;
    v_sum = v_hi + 50'(v_fr[33:32]);
    v_new = (v_sum[49:48] != 2'b00) ? 48'hFFFF_FFFF_FFFF : v_sum[47:0];
    m_mag = s3_nm_r[31] ? (~s3_nm_r + 32'd1) : s3_nm_r;
    num   = {32'd0, step_r} * {32'd0, m_mag};
  end

  // square root and divider steps
  always_comb begin
    sq_nxt[0].x    = v_new;
    sq_nxt[0].root = '0;
    sq_nxt[0].rem  = '0;
    sq_nxt[0].num  = num;
    sq_nxt[0].neg  = s3_nm_r[31];
    sq_nxt[0].meta = s3_meta_r;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      sq_nxt[k] = sq_step(sq_r[k-1]);
    end

    den    = {1'b0, sq_r[SQ_STAGES].root} + 25'd1;
    n_full = sq_r[SQ_STAGES].num + {32'd0, den, 7'd0};
    n_shr  = n_full[63:8];
    dv_nxt[0].den  = den;
    dv_nxt[0].rem  = {2'b00, n_shr[55:33]};
    dv_nxt[0].lo   = n_shr[32:0];
    dv_nxt[0].quo  = '0;
    dv_nxt[0].ovf  = ({2'b00, n_shr[55:33]} >= den);
    dv_nxt[0].neg  = sq_r[SQ_STAGES].neg;
    dv_nxt[0].meta = sq_r[SQ_STAGES].meta;
    for (int k = 1; k <= DV_STAGES; k++) begin
      dv_nxt[k] = dv_step(dv_r[k-1]);
    end
  end

  // apply the update and saturate
  always_comb begin
    q_ext = dv_r[DV_STAGES].ovf ? 34'h2_0000_0000 : {1'b0, dv_r[DV_STAGES].quo};
    if (dv_r[DV_STAGES].neg) begin
      res_full = 36'($signed(dv_r[DV_STAGES].meta.p)) + $signed({2'b00, q_ext});
    end else begin
      res_full = 36'($signed(dv_r[DV_STAGES].meta.p)) - $signed({2'b00, q_ext});
    end
    if (res_full > 36'sd2147483647) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res_full < -36'sd2147483648) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = res_full[31:0];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      sq_vld_r <= '0;
      dv_vld_r <= '0;
    end else if (adv) begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      sq_vld_r <= {sq_vld_r[SQ_STAGES-1:0], s3_vld_r};
      dv_vld_r <= {dv_vld_r[DV_STAGES-1:0], sq_vld_r[SQ_STAGES]};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r.idx <= in_entry_index;
      s1_meta_r.p   <= in_param_value;
      s1_g_r        <= in_gradient;
      s2_meta_r     <= s1_meta_r;
      s2_pm_r       <= s2_pm_nxt;
      s2_pg_r       <= s2_pg_nxt;
      s2_sq_r       <= s2_sq_nxt;
      s2_pvl_r      <= s2_pvl_nxt;
      s2_pvh_r      <= s2_pvh_nxt;
      s3_meta_r     <= s2_meta_r;
      s3_nm_r       <= s3_nm_nxt;
      s3_pvl_r      <= s2_pvl_r;
      s3_pvh_r      <= s2_pvh_r;
      s3_pbl_r      <= s3_pbl_nxt;
      s3_pbh_r      <= s3_pbh_nxt;
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      for (int k = 0; k <= DV_STAGES; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && dv_vld_r[DV_STAGES]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dv_vld_r[DV_STAGES]) begin
      out_index_r <= dv_r[DV_STAGES].meta.idx;
      out_param_r <= res_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_new_param = $signed(out_param_r);

  a_rmw_s12_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_vld_r) |-> (s1_meta_r.idx != s2_meta_r.idx))
    else $error("two requests to one entry in stages 1 and 2");

  a_rmw_s13_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s3_vld_r) |-> (s1_meta_r.idx != s3_meta_r.idx))
    else $error("two requests to one entry in stages 1 and 3");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_vld_r && !s3_vld_r && !out_valid_r))
    else $error("pipeline active during clearing pass");

endmodule

// ----- sim/tb_adam_optimizer_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam update engine testbench
// Drives parameter update requests through the engine under several idle and
// stall patterns and step size settings, predicts each updated parameter from
// a model of the moment stores and checks every result in order.
// ----------------------------------------------------------------------------

class adam_scoreboard;
  logic [31:0] step_size;
  logic [31:0] m_store [int];
  logic [47:0] v_store [int];
  logic [15:0] idx_q [$];
  logic [31:0] param_q [$];
  int          errors;

  function new();
    step_size = adam_pkg::STEP_RESET;
    errors    = 0;
  endfunction

  function automatic logic [23:0] root48(logic [47:0] x);
    logic [47:0] r;
    logic [47:0] b;
    r = 0;
    b = 48'h1 << 46;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[23:0];
  endfunction

  function void note_request(logic [15:0] idx, logic signed [31:0] g,
                             logic signed [31:0] p);
    logic signed [31:0] m;
    logic [47:0]        v;
    logic signed [95:0] msum;
    logic signed [63:0] nm;
    logic [31:0]        ag;
    logic [63:0]        g2;
    logic [95:0]        vsum;
    logic [63:0]        den;
    logic [63:0]        mag;
    logic [95:0]        q;
    logic signed [63:0] res;
    m = m_store.exists(idx) ? m_store[idx] : 32'd0;
    v = v_store.exists(idx) ? v_store[idx] : 48'd0;
    msum = $signed({64'd0, adam_pkg::M_KEEP}) * m
         + $signed({64'd0, adam_pkg::M_TAKE}) * g + 96'sd2147483648;
    nm = 64'(msum >>> 32);
    m_store[idx] = nm[31:0];
    ag = (g < 0) ? 32'(-g) : 32'(g);
    g2 = ({32'd0, ag} * {32'd0, ag}) >> 16;
    vsum = 96'(v) * 96'(adam_pkg::V_KEEP) + 96'(g2) * 96'(adam_pkg::V_TAKE)
         + 96'd2147483648;
    vsum = vsum >> 32;
    if (vsum > 96'hFFFFFFFFFFFF) vsum = 96'hFFFFFFFFFFFF;
    v_store[idx] = vsum[47:0];
    den = 64'(root48(vsum[47:0])) + 1;
    mag = (nm < 0) ? 64'(-nm) : 64'(nm);
    q = (96'(step_size) * 96'(mag) + 96'(den) * 128) / (96'(den) * 256);
    res = (nm < 0) ? 64'(p) + $signed(q[63:0]) : 64'(p) - $signed(q[63:0]);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    idx_q.push_back(idx);
    param_q.push_back(res[31:0]);
  endfunction

  function void check_result(logic [15:0] idx, logic [31:0] p);
    logic [15:0] e_idx;
    logic [31:0] e_p;
    if (idx_q.size() == 0) begin
      $error("unexpected result index %0d new_param %0h", idx, p);
      errors++;
      return;
    end
    e_idx = idx_q.pop_front();
    e_p   = param_q.pop_front();
    if (idx !== e_idx) begin
      $error("out_index expected %0d actual %0d", e_idx, idx);
      errors++;
    end
    if (p !== e_p) begin
      $error("new_param expected %0h actual %0h", e_p, p);
      errors++;
    end
  endfunction
endclass

module tb_adam_optimizer_update;
  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [31:0]        cfg_step_size;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        in_entry_index;
  logic signed [31:0] in_gradient;
  logic signed [31:0] in_param_value;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_index;
  logic signed [31:0] out_new_param;

  adam_scoreboard sb;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off;
  longint cycles;
  int   sent;
  int   results;

  adam_optimizer_update i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_step_size  (cfg_step_size),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_entry_index (in_entry_index),
    .in_gradient    (in_gradient),
    .in_param_value (in_param_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_index      (out_index),
    .out_new_param  (out_new_param)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sample accepted results
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_index, out_new_param);
      results++;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(logic [15:0] idx, logic [31:0] g, logic [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_entry_index <= idx;
    in_gradient    <= g;
    in_param_value <= p;
    do @(posedge clk); while (in_stall);
    sb.note_request(idx, g, p);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.idx_q.size() != 0) @(negedge clk);
    while (n < 80) begin
      @(negedge clk);
      n++;
    end
  endtask

  task automatic write_step(logic [31:0] s);
    drain();
    cfg_wr_en     <= 1'b1;
    cfg_step_size <= s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.step_size = s;
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(65535) - 32768;
      2: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(33554431) - 16777216;
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    int k;
    logic [15:0] idx;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (k = 0; k < n; k++) begin
      // hot indices hit the read-modify-write hazard
      idx = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(7));
      send_request(idx, rand_word($urandom_range(3)), rand_word($urandom_range(3)));
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_step_size  = 32'd0;
    in_valid       = 1'b0;
    in_entry_index = 16'd0;
    in_gradient    = 32'sd0;
    in_param_value = 32'sd0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    sent           = 0;
    results        = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes at reset, maximum and zero step size, repeated index
    send_request(16'd0, 32'sd0, 32'sd0);
    send_request(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_request(16'hFFFF, 32'h80000000, 32'h80000000);
    send_request(16'd1, 32'h80000000, 32'h7FFFFFFF);
    send_request(16'd1, 32'h80000000, 32'h7FFFFFFF);
    send_request(16'd2, 32'h7FFFFFFF, 32'h80000000);
    send_request(16'd2, 32'h7FFFFFFF, 32'h80000000);
    send_request(16'd3, 32'sd1, 32'sd0);
    send_request(16'd3, -32'sd1, 32'sd0);
    write_step(32'hFFFFFFFF);
    send_request(16'd4, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_request(16'd5, 32'h80000000, 32'h80000000);
    send_request(16'd6, 32'sd16777216, 32'sd0);
    send_request(16'd6, -32'sd16777216, 32'sd0);
    write_step(32'd0);
    send_request(16'd7, 32'h7FFFFFFF, 32'h12345678);
    send_request(16'hAAAA, 32'h55555555, 32'hAAAAAAAA);

    write_step(32'd16777);
    random_phase(250, 0, 0);
    write_step(32'h01000000);
    random_phase(250, 53, 0);
    write_step(32'hFFFFFFFF);
    random_phase(250, 0, 53);
    write_step(32'd0);
    random_phase(100, 17, 17);
    write_step($urandom());
    hold_off = 300;
    random_phase(250, 17, 17);

    drain();
    $display("Sent %0d update requests, checked %0d results over five step sizes",
             sent, results);
    $display("and four idle/stall mixes including a long receiver hold-off.");
    if (sb.errors == 0 && sb.idx_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
